/* design/ole_pkg.sv */
// shared constants and command codes for the ordered list engine
`default_nettype none
package ole_pkg;
    localparam int Capacity   = 64;
    localparam int ValueWidth = 32;
    localparam int AddrWidth  = $clog2(Capacity);
    localparam int CountWidth = $clog2(Capacity + 1);
    localparam int CmdWidth   = 3;
    localparam int InWidth    = 32;
    localparam int ResWidth   = 7;

    typedef logic [CmdWidth-1:0] cmd_t;
    localparam cmd_t CmdAdd     = 3'd0;
    localparam cmd_t CmdDelete  = 3'd1;
    localparam cmd_t CmdDedupe  = 3'd2;
    localparam cmd_t CmdReverse = 3'd3;
    localparam cmd_t CmdSorted  = 3'd4;
    localparam cmd_t CmdLength  = 3'd5;
endpackage
`default_nettype wire

/* design/ole_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module ole_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

/* design/ordered_list_engine_unit.sv */
// ordered list engine: top level with sequencer over one element ram
// length answers from the count register; add, delete, sorted, reverse and dedupe walk the ram
// dedupe time is set by the single ram read port walking pairs of elements
// throughput: one item at a time; the next item is taken once the result register is free
// every stored element moves through the one read port and one write port of the ram
// reset: synchronous active-low aresetn clears the count and control; ram content stays
`default_nettype none
module ordered_list_engine_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic [31:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [6:0]       m_result
);
    localparam int AW = ole_pkg::AddrWidth;
    localparam int CW = ole_pkg::CountWidth;
    localparam int VW = ole_pkg::ValueWidth;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SHIFT_RD, ST_SHIFT_WR, ST_SCAN_RD, ST_SCAN_CHK,
        ST_REV_RDA, ST_REV_RDB, ST_REV_WR,
        ST_DD_RDI, ST_DD_RDJ, ST_DD_CHK, ST_DONE
    } state_t;

    state_t             state_reg;
    ole_pkg::cmd_t      cmd_reg;
    logic [VW-1:0]      val_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      i_reg, j_reg, kept_reg;
    logic [VW-1:0]      hold_reg;
    logic               found_reg, first_reg;
    logic               m_valid_reg;
    logic [6:0]         m_result_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [VW-1:0]      wr_data, rd_data;

    // element store
    ole_ram #(.Width(VW), .Depth(ole_pkg::Capacity)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // ram address and write control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_reg[AW-1:0];
        wr_data = rd_data;
        rd_addr = i_reg[AW-1:0];
        case (state_reg)
            ST_SHIFT_WR: begin
                // shifted element, or the new value at the front
                wr_en   = 1'b1;
                wr_addr = AW'(i_reg + CW'(1));
                wr_data = (i_reg == {CW{1'b1}}) ? val_reg : rd_data;
            end
            ST_SCAN_CHK: begin
                // delete: after a match, copy each element one slot down
                wr_en   = found_reg && (cmd_reg == ole_pkg::CmdDelete);
                wr_addr = AW'(i_reg - CW'(1));
            end
            ST_REV_RDB: rd_addr = j_reg[AW-1:0];
            ST_REV_WR: begin
                wr_en   = 1'b1;
                wr_addr = i_reg[AW-1:0];
            end
            ST_DD_RDJ: rd_addr = j_reg[AW-1:0];
            ST_DD_CHK: begin
                wr_en   = (j_reg == kept_reg);
                wr_addr = kept_reg[AW-1:0];
                wr_data = hold_reg;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        cmd_reg   <= s_command;
                        val_reg   <= VW'(signed'(s_value));
                        found_reg <= 1'b0;
                        first_reg <= 1'b1;
                        kept_reg  <= '0;
                        m_result_reg <= '0;
                        case (s_command)
                            ole_pkg::CmdAdd: begin
                                if (count_reg >= CW'(ole_pkg::Capacity)) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    i_reg     <= count_reg - CW'(1);
                                    state_reg <= (count_reg == '0) ? ST_SHIFT_WR
                                                                   : ST_SHIFT_RD;
                                end
                            end
                            ole_pkg::CmdDelete, ole_pkg::CmdSorted: begin
                                i_reg     <= '0;
                                m_result_reg <= (s_command == ole_pkg::CmdSorted)
                                                ? 7'd1 : 7'd0;
                                state_reg <= (count_reg == '0) ? ST_DONE : ST_SCAN_RD;
                            end
                            ole_pkg::CmdDedupe: begin
                                i_reg     <= '0;
                                state_reg <= (count_reg == '0) ? ST_DONE : ST_DD_RDI;
                            end
                            ole_pkg::CmdReverse: begin
                                i_reg     <= '0;
                                j_reg     <= count_reg - CW'(1);
                                state_reg <= (count_reg < CW'(2)) ? ST_DONE : ST_REV_RDA;
                            end
                            ole_pkg::CmdLength: begin
                                m_result_reg <= 7'(count_reg);
                                state_reg    <= ST_DONE;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                // add: move elements up from the back, then write the front
                ST_SHIFT_RD: state_reg <= ST_SHIFT_WR;
                ST_SHIFT_WR: begin
                    if (i_reg == {CW{1'b1}}) begin
                        count_reg    <= count_reg + CW'(1);
                        m_result_reg <= 7'd1;
                        state_reg    <= ST_DONE;
                    end else if (i_reg == '0) begin
                        i_reg     <= {CW{1'b1}};
                        state_reg <= ST_SHIFT_WR;
                    end else begin
                        i_reg     <= i_reg - CW'(1);
                        state_reg <= ST_SHIFT_RD;
                    end
                end
                ST_SCAN_RD: state_reg <= ST_SCAN_CHK;
                ST_SCAN_CHK: begin
                    state_reg <= ST_SCAN_RD;
                    i_reg     <= i_reg + CW'(1);
                    hold_reg  <= rd_data;
                    if (cmd_reg == ole_pkg::CmdDelete) begin
                        if (!found_reg && rd_data == val_reg) begin
                            found_reg <= 1'b1;
                        end
                        if (i_reg + CW'(1) == count_reg) begin
                            state_reg <= ST_DONE;
                            if (found_reg || rd_data == val_reg) begin
                                count_reg    <= count_reg - CW'(1);
                                m_result_reg <= 7'd1;
                            end
                        end
                    end else begin
                        if (i_reg != '0 && $signed(hold_reg) > $signed(rd_data)) begin
                            m_result_reg <= 7'd0;
                            state_reg    <= ST_DONE;
                        end else if (i_reg + CW'(1) == count_reg) begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                // reverse: swap the pair i, j
                ST_REV_RDA: state_reg <= ST_REV_RDB;
                ST_REV_RDB: begin
                    hold_reg  <= rd_data;
                    state_reg <= ST_REV_WR;
                end
                ST_REV_WR: begin
                    if (first_reg) begin
                        // wrote b at i; the read of i this cycle still returns a, write it at j
                        first_reg <= 1'b0;
                        i_reg     <= j_reg;
                        j_reg     <= i_reg;
                    end else begin
                        first_reg <= 1'b1;
                        if (j_reg + CW'(1) >= i_reg - CW'(1)) begin
                            state_reg <= ST_DONE;
                        end else begin
                            i_reg     <= j_reg + CW'(1);
                            j_reg     <= i_reg - CW'(1);
                            state_reg <= ST_REV_RDA;
                        end
                    end
                end
                // dedupe: hold element i, compare with kept entries 0..kept-1
                ST_DD_RDI: state_reg <= ST_DD_RDJ;
                ST_DD_RDJ: begin
                    if (first_reg) begin
                        hold_reg  <= rd_data;
                        first_reg <= 1'b0;
                        j_reg     <= '0;
                        state_reg <= (kept_reg == '0) ? ST_DD_CHK : ST_DD_RDJ;
                    end else begin
                        state_reg <= ST_DD_CHK;
                    end
                end
                ST_DD_CHK: begin
                    if (j_reg != kept_reg && rd_data != hold_reg) begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= (j_reg + CW'(1) == kept_reg) ? ST_DD_CHK : ST_DD_RDJ;
                    end else begin
                        if (j_reg == kept_reg) begin
                            kept_reg <= kept_reg + CW'(1);
                        end
                        first_reg <= 1'b1;
                        if (i_reg + CW'(1) == count_reg) begin
                            count_reg    <= (j_reg == kept_reg) ? kept_reg + CW'(1) : kept_reg;
                            m_result_reg <= 7'(count_reg - ((j_reg == kept_reg)
                                            ? kept_reg + CW'(1) : kept_reg));
                            state_reg    <= ST_DONE;
                        end else begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= ST_DD_RDI;
                        end
                    end
                end
                ST_DONE: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ole_pkg::Capacity))
        else $error("count above capacity");
    // no item taken while a result waits
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !s_ready)
        else $error("input taken while result pending");
    // a result follows the done state
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |=> m_valid_reg)
        else $error("result not raised after done");
    // count only changes while busy
    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && $past(state_reg) == ST_IDLE && $past(aresetn))
        |-> $stable(count_reg))
        else $error("count moved while idle");
endmodule
`default_nettype wire
